### rtl/fat_timestamp_calendar_clock_core_defines.svh
// Assertion macros shared by the FAT timestamp calendar clock RTL.
// Needs nothing else; files that check their own logic include this header.
`ifndef FAT_TIMESTAMP_CALENDAR_CLOCK_CORE_DEFINES_SVH
`define FAT_TIMESTAMP_CALENDAR_CLOCK_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define FAT_TCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define FAT_TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fat_tcc_pkg.sv
// Types and constants for the FAT timestamp calendar clock.
// Used by fat_tcc_next and fat_timestamp_calendar_clock_core; depends on nothing.
`timescale 1ns / 1ps

package fat_tcc_pkg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } op_t;

    // Field order matches the FAT time word, so the struct is the word itself.
    typedef struct packed {
        logic [6:0] year_offset;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_count;
        logic [5:0] minute_count;
        logic [4:0] two_second_count;
    } cal_t;

    localparam logic [4:0] TwoSecPerMin  = 5'd30;
    localparam logic [5:0] MinPerHour    = 6'd60;
    localparam logic [4:0] HourPerDay    = 5'd24;
    localparam logic [3:0] MonthPastEnd  = 4'd13;
    localparam logic [3:0] MonthFeb      = 4'd2;
    localparam logic [6:0] NoLeapOffset  = 7'd120;
    // The low seven bits of 1980; the year offset is taken modulo 128.
    localparam logic [6:0] BaseYearLow   = 7'(1980 % 128);

    // Days in a month for a non-leap year; codes with no month count as 31.
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        case (month)
            4'd2:    days = 5'd28;
            4'd4:    days = 5'd30;
            4'd6:    days = 5'd30;
            4'd9:    days = 5'd30;
            4'd11:   days = 5'd30;
            default: days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

### rtl/fat_tcc_next.sv
// Next calendar state: a two-second tick with carries, or a direct load.
// Depends on fat_tcc_pkg.
`timescale 1ns / 1ps

module fat_tcc_next
    import fat_tcc_pkg::*;
(
    input  cal_t       cur,
    input  op_t        operation,
    input  logic [11:0] set_year,
    input  logic [3:0] set_month,
    input  logic [4:0] set_day,
    input  logic [4:0] set_hour,
    input  logic [5:0] set_minute,
    input  logic [5:0] set_second,
    output cal_t       nxt
);

    cal_t       tick_val;
    cal_t       load_val;
    logic       leap;
    logic [4:0] dim;

    always_comb
    begin
        tick_val = cur;

        tick_val.two_second_count = cur.two_second_count + 5'd1;
        if (tick_val.two_second_count == TwoSecPerMin)
        begin
            tick_val.two_second_count = '0;
            tick_val.minute_count     = cur.minute_count + 6'd1;
        end

        // Each carry test checks the field, so a load of minute 60, hour 24,
        // month 13 or a bad day rolls over on a tick with no incoming carry.
        if (tick_val.minute_count == MinPerHour)
        begin
            tick_val.minute_count = '0;
            tick_val.hour_count   = cur.hour_count + 5'd1;
        end

        if (tick_val.hour_count == HourPerDay)
        begin
            tick_val.hour_count   = '0;
            tick_val.day_of_month = cur.day_of_month + 5'd1;
        end

        if ((tick_val.day_of_month == '0) || (tick_val.day_of_month > dim))
        begin
            tick_val.day_of_month = 5'd1;
            tick_val.month_number = cur.month_number + 4'd1;
        end

        if (tick_val.month_number == MonthPastEnd)
        begin
            tick_val.month_number = 4'd1;
            tick_val.year_offset  = cur.year_offset + 7'd1;
        end
    end

    // Month and year never change before the day check, so the month length
    // comes straight from the current state.
    assign leap = (cur.year_offset[1:0] == 2'b00) && (cur.year_offset != NoLeapOffset);
    assign dim  = ((cur.month_number == MonthFeb) && leap) ? 5'd29
                                                          : month_days(cur.month_number);

    always_comb
    begin
        load_val.year_offset      = set_year[6:0] - BaseYearLow;
        load_val.month_number     = set_month;
        load_val.day_of_month     = set_day;
        load_val.hour_count       = set_hour;
        load_val.minute_count     = set_minute;
        load_val.two_second_count = set_second[5:1];
    end

    assign nxt = (operation == OP_SET) ? load_val : tick_val;

endmodule

### rtl/fat_timestamp_calendar_clock_core.sv
// A beat is captured in the input stage; its result is then registered in the calendar state.
// Throughput: one beat per cycle, with no gaps, as long as out_ready stays high.
// The limit is the single calendar update (fat_tcc_next) between input and state.
// Reset clears the stage and result valid flags and all calendar fields to zero.
// Depends on fat_tcc_pkg, fat_tcc_next and the assertion macro header.
`timescale 1ns / 1ps
`include "fat_timestamp_calendar_clock_core_defines.svh"

module fat_timestamp_calendar_clock_core
    import fat_tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [11:0] set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,
    input  logic [4:0]  set_hour,
    input  logic [5:0]  set_minute,
    input  logic [5:0]  set_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] packed_time
);

    // The design has two register stages. The input stage captures one beat.
    // The calendar state register doubles as the result register: every beat
    // produces exactly one result, which is the packed state after the update,
    // so the state is only written when the result slot is free to take it.

    logic        stage_valid_reg;
    op_t         stage_op_reg;
    logic [11:0] stage_year_reg;
    logic [3:0]  stage_month_reg;
    logic [4:0]  stage_day_reg;
    logic [4:0]  stage_hour_reg;
    logic [5:0]  stage_minute_reg;
    logic [5:0]  stage_second_reg;

    cal_t        cal_reg;
    cal_t        cal_next;
    logic        out_valid_reg;

    logic        advance;
    logic        in_fire;

    // A staged beat moves into the result register when the result slot is
    // empty or its current result is being taken in this same cycle.
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // Payload of the input stage needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_op_reg     <= op_t'(operation);
            stage_year_reg   <= set_year;
            stage_month_reg  <= set_month;
            stage_day_reg    <= set_day;
            stage_hour_reg   <= set_hour;
            stage_minute_reg <= set_minute;
            stage_second_reg <= set_second;
        end
    end

    fat_tcc_next u_next (
        .cur        (cal_reg),
        .operation  (stage_op_reg),
        .set_year   (stage_year_reg),
        .set_month  (stage_month_reg),
        .set_day    (stage_day_reg),
        .set_hour   (stage_hour_reg),
        .set_minute (stage_minute_reg),
        .set_second (stage_second_reg),
        .nxt        (cal_next)
    );

    // The calendar is architectural state, so it is reset to all zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                cal_reg <= cal_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign packed_time = cal_reg;

    `FAT_TCC_ASSERT_NEXT(a_advance_gives_result, clk, rst_n,
        advance, out_valid_reg, "staged beat did not produce a result")
    `FAT_TCC_ASSERT_NEXT(a_state_holds_while_waiting, clk, rst_n,
        out_valid_reg && !out_ready, $stable(cal_reg), "calendar moved under a pending result")
    `FAT_TCC_ASSERT_NEXT(a_stage_not_dropped, clk, rst_n,
        stage_valid_reg && !advance, stage_valid_reg, "staged beat lost before it advanced")
    `FAT_TCC_ASSERT_NOW(a_ready_when_empty, clk, rst_n,
        !stage_valid_reg, in_ready, "input stage empty but not ready")

endmodule
